FILE: sv/paisd_pkg.sv
// ----------------------------------------------------------------------------
// paisd_pkg
// Shared types and codes for the packed table with insert, search, delete
// and dump commands.
// ----------------------------------------------------------------------------
`default_nettype none

package paisd_pkg;

  // Widths of the result fields
  localparam int unsigned IndexW = 6;
  localparam int unsigned ValueW = 32;

  // Command codes
  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_INSERT = 2'd0;
  localparam opcode_t OP_DUMP   = 2'd1;
  localparam opcode_t OP_SEARCH = 2'd2;
  localparam opcode_t OP_DELETE = 2'd3;

  // Result status codes
  typedef logic [2:0] status_t;
  localparam status_t ST_INSERTED  = 3'd0;
  localparam status_t ST_FULL      = 3'd1;
  localparam status_t ST_EMPTY     = 3'd2;
  localparam status_t ST_FOUND     = 3'd3;
  localparam status_t ST_NOT_FOUND = 3'd4;
  localparam status_t ST_DELETED   = 3'd5;
  localparam status_t ST_DUMPED    = 3'd6;

  // One command item
  typedef struct packed {
    opcode_t                  opcode;
    logic signed [ValueW-1:0] operand_value;
  } req_t;

  // One result item
  typedef struct packed {
    status_t                  status;
    logic [IndexW-1:0]        entry_index;
    logic signed [ValueW-1:0] entry_value;
    logic                     last_result;
  } rsp_t;

endpackage

`default_nettype wire

FILE: sv/packed_array_insert_search_delete.sv
// ----------------------------------------------------------------------------
// packed_array_insert_search_delete
// Packed unsorted table in one synchronous RAM with append, linear search,
// delete with shift-down, and dump of all entries.
// ----------------------------------------------------------------------------
// Insert, and any command on an empty table: one result, in the cycle after start.
// Search: one RAM read per cycle; the result follows the match or the last entry.
// Dump: count results on consecutive cycles, in index order.
// Delete: scan, then shift later entries down one per cycle; the result follows the
//   last move, or the scan when the match is last. Results cannot be stalled.
// The next item may start in the final result's cycle; reset clears the count.
`default_nettype none

module packed_array_insert_search_delete #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  paisd_pkg::req_t       req,
  output logic                  busy,
  output logic                  valid,
  output paisd_pkg::rsp_t       result
);
  import paisd_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

  state_t                   state;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         ptr;
  logic                     rd_vld;
  logic [IDX_W-1:0]         rd_idx;
  opcode_t                  op;
  logic signed [ValueW-1:0] operand;

  // Table RAM and its ports
  logic signed [ValueW-1:0] mem [CAPACITY];
  logic signed [ValueW-1:0] rdata;
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  logic signed [ValueW-1:0] mem_wdata;
  logic                     mem_re;
  logic [IDX_W-1:0]         mem_raddr;

  logic                     accept;
  logic                     full;
  logic                     hit;
  logic                     is_last;
  logic [CNT_W-1:0]         last_idx;
  logic                     issue;

  function automatic rsp_t pack_rsp(status_t st, logic [IndexW-1:0] idx,
                                    logic signed [ValueW-1:0] val, logic last);
    rsp_t r;
    r.status      = st;
    r.entry_index = idx;
    r.entry_value = val;
    r.last_result = last;
    return r;
  endfunction

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign full     = (count >= CNT_W'(CAPACITY));
  assign last_idx = count - CNT_W'(1);
  assign is_last  = (CNT_W'(rd_idx) == last_idx);

  // Compare the returned entry against the operand during search and delete
  assign hit = rd_vld && (state == S_SCAN) && (op != OP_DUMP) && (rdata == operand);

  // Issue one read per cycle while entries remain; stop on a match
  assign issue = ((state == S_SCAN) || (state == S_SHIFT)) && (ptr < count) && !hit;

  // Read port follows the walk pointer
  assign mem_re    = issue;
  assign mem_raddr = ptr[IDX_W-1:0];

  // Write port: append on insert, move an entry down one place on shift
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[IDX_W-1:0];
    mem_wdata = req.operand_value;
    if (state == S_SHIFT) begin
      mem_we    = rd_vld;
      mem_waddr = rd_idx - IDX_W'(1);
      mem_wdata = rdata;
    end else if (accept && (req.opcode == OP_INSERT) && !full) begin
      mem_we = 1'b1;
    end
  end

  // Table RAM with registered read data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // Hold the command and track read addresses in flight
  always_ff @(posedge clk) begin
    rd_idx <= ptr[IDX_W-1:0];
    if (accept) begin
      op      <= req.opcode;
      operand <= req.operand_value;
    end
  end

  // Sequence the commands and drive the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      ptr    <= '0;
      rd_vld <= 1'b0;
      valid  <= 1'b0;
    end else begin
      valid  <= 1'b0;
      rd_vld <= issue;
      if (issue) begin
        ptr <= ptr + CNT_W'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            ptr <= '0;
            if (req.opcode == OP_INSERT) begin
              valid <= 1'b1;
              if (full) begin
                result <= pack_rsp(ST_FULL, '0, '0, 1'b1);
              end else begin
                count  <= count + CNT_W'(1);
                result <= pack_rsp(ST_INSERTED, '0, '0, 1'b1);
              end
            end else if (count == '0) begin
              valid  <= 1'b1;
              result <= pack_rsp(ST_EMPTY, '0, '0, 1'b1);
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd_vld) begin
            if (op == OP_DUMP) begin
              valid  <= 1'b1;
              result <= pack_rsp(ST_DUMPED, IndexW'(rd_idx), rdata, is_last);
              if (is_last) begin
                state <= S_IDLE;
              end
            end else if (hit) begin
              if (op == OP_SEARCH) begin
                valid  <= 1'b1;
                result <= pack_rsp(ST_FOUND, IndexW'(rd_idx), rdata, 1'b1);
                state  <= S_IDLE;
              end else if (is_last) begin
                valid  <= 1'b1;
                count  <= last_idx;
                result <= pack_rsp(ST_DELETED, '0, '0, 1'b1);
                state  <= S_IDLE;
              end else begin
                ptr   <= CNT_W'(rd_idx) + CNT_W'(1);
                state <= S_SHIFT;
              end
            end else if (is_last) begin
              valid  <= 1'b1;
              result <= pack_rsp(ST_NOT_FOUND, '0, '0, 1'b1);
              state  <= S_IDLE;
            end
          end
        end
        S_SHIFT: begin
          if (rd_vld && is_last) begin
            valid  <= 1'b1;
            count  <= last_idx;
            result <= pack_rsp(ST_DELETED, '0, '0, 1'b1);
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // Final result of an item frees the block
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    valid && result.last_result |-> !busy)
    else $error("busy after final result");

  // Intermediate dump results keep the block busy
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    valid && !result.last_result |-> busy && (result.status == ST_DUMPED))
    else $error("non-final result outside dump");

  // Shift write never lands on the entry being read
  a_no_collide: assert property (@(posedge clk) disable iff (rst)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("read and write to the same entry");

endmodule

`default_nettype wire

FILE: test/table_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// table_scoreboard_pkg
// Shadow copy of the packed table. It predicts the results of each accepted
// command and checks every result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
package table_scoreboard_pkg;

  import paisd_pkg::*;

  // Capacity used by the shadow table and by the instance under test
  localparam int TableCap = 64;

  class table_scoreboard;
    logic signed [ValueW-1:0] entries [TableCap];
    int                       count;
    rsp_t                     pending [$];
    int                       failures;

    function new();
      count    = 0;
      failures = 0;
    endfunction

    // Predict the results of one accepted command, then update the shadow table
    function void note_command(req_t cmd);
      int   hit;
      rsp_t r;
      hit           = -1;
      r             = '0;
      r.last_result = 1'b1;
      if (cmd.opcode == OP_INSERT) begin
        if (count >= TableCap) begin
          r.status = ST_FULL;
        end else begin
          entries[count] = cmd.operand_value;
          count++;
          r.status = ST_INSERTED;
        end
        pending.push_back(r);
      end else if (count == 0) begin
        // search, delete and dump all report an empty table the same way
        r.status = ST_EMPTY;
        pending.push_back(r);
      end else if (cmd.opcode == OP_DUMP) begin
        for (int i = 0; i < count; i++) begin
          r.status      = ST_DUMPED;
          r.entry_index = IndexW'(i);
          r.entry_value = entries[i];
          r.last_result = (i == count - 1);
          pending.push_back(r);
        end
      end else begin
        // scan from the back so the first match from the front wins
        for (int i = count - 1; i >= 0; i--) begin
          if (entries[i] == cmd.operand_value) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else if (cmd.opcode == OP_SEARCH) begin
          r.status      = ST_FOUND;
          r.entry_index = IndexW'(hit);
          r.entry_value = entries[hit];
        end else begin
          // close the gap left by the removed entry
          for (int j = hit; j < count - 1; j++) entries[j] = entries[j + 1];
          count--;
          r.status = ST_DELETED;
        end
        pending.push_back(r);
      end
    endfunction

    // Compare one result strobe with the oldest prediction
    function void check_response(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: status %0d index %0d value %0d last %0d",
               got.status, got.entry_index, got.entry_value, got.last_result);
        failures++;
      end else begin
        want = pending.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          failures++;
        end
        if (got.entry_index !== want.entry_index) begin
          $error("entry_index: expected %0d, got %0d", want.entry_index, got.entry_index);
          failures++;
        end
        if (got.entry_value !== want.entry_value) begin
          $error("entry_value: expected %0d, got %0d", want.entry_value, got.entry_value);
          failures++;
        end
        if (got.last_result !== want.last_result) begin
          $error("last_result: expected %0d, got %0d", want.last_result, got.last_result);
          failures++;
        end
      end
    endfunction
  endclass

endpackage

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives insert, search, delete and dump commands into the packed table:
// a directed opening on the corner cases, then random commands that fill the
// table to full and drain it again, with random idle bursts on the command side.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import paisd_pkg::*;
  import table_scoreboard_pkg::*;

  localparam int RandomItems = 350;
  localparam int QuietTail   = 50;
  localparam int CycleLimit  = 500000;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  req_t req   = '0;
  logic busy;
  logic valid;
  rsp_t result;
  int   cycles = 0;

  table_scoreboard board = new();

  packed_array_insert_search_delete #(
    .CAPACITY(TableCap)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .busy  (busy),
    .valid (valid),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every result strobe at the edge that ends its cycle
  always @(posedge clk) begin
    if (!rst && valid) board.check_response(result);
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Present one item and hold it until the block takes it
  task automatic send_command(input opcode_t op, input logic signed [ValueW-1:0] v);
    req_t cmd;
    cmd.opcode        = op;
    cmd.operand_value = v;
    start <= 1'b1;
    req   <= cmd;
    do @(posedge clk); while (busy);
    board.note_command(cmd);
  endtask

  // Drop start for a burst of cycles, with junk on the item bus
  task automatic idle_gap(input int n);
    start <= 1'b0;
    req   <= {opcode_t'($urandom_range(0, 3)), ValueW'($urandom)};
    repeat (n) @(posedge clk);
  endtask

  // Mostly stored values and a small pool, so that matches and duplicates occur
  function automatic logic signed [ValueW-1:0] pick_operand();
    int unsigned r;
    int          k;
    r = $urandom_range(0, 9);
    if (board.count > 0 && r < 6) begin
      return board.entries[$urandom_range(0, board.count - 1)];
    end else if (r < 8) begin
      k = $urandom_range(0, 6);
      return ValueW'(k - 3);
    end
    return ValueW'($urandom);
  endfunction

  // Weight the mix toward filling or toward draining the table
  task automatic random_command(input bit growing);
    int unsigned pick;
    opcode_t     op;
    pick = $urandom_range(0, 99);
    if (growing) begin
      op = pick < 70 ? OP_INSERT : pick < 85 ? OP_SEARCH : pick < 93 ? OP_DELETE : OP_DUMP;
    end else begin
      op = pick < 15 ? OP_INSERT : pick < 35 ? OP_SEARCH : pick < 88 ? OP_DELETE : OP_DUMP;
    end
    send_command(op, pick_operand());
  endtask

  initial begin
    bit growing;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Every command on an empty table
    send_command(OP_DUMP, 32'sd0);
    send_command(OP_SEARCH, 32'sd5);
    send_command(OP_DELETE, 32'sd5);
    // Extremes and a duplicate
    send_command(OP_INSERT, $signed(32'h8000_0000));
    send_command(OP_INSERT, $signed(32'h7FFF_FFFF));
    send_command(OP_INSERT, 32'sd0);
    send_command(OP_INSERT, -32'sd1);
    send_command(OP_INSERT, 32'sd7);
    send_command(OP_INSERT, 32'sd7);
    send_command(OP_DUMP, $signed(32'hFFFF_FFFF));
    send_command(OP_SEARCH, $signed(32'h8000_0000));
    send_command(OP_SEARCH, 32'sd7);
    // Misses leave the table alone
    send_command(OP_SEARCH, 32'sd12345);
    send_command(OP_DELETE, 32'sd12345);
    // Delete the first of two matches, then the head and the tail
    send_command(OP_DELETE, 32'sd7);
    send_command(OP_SEARCH, 32'sd7);
    send_command(OP_DELETE, $signed(32'h8000_0000));
    send_command(OP_DELETE, 32'sd7);
    send_command(OP_DUMP, 32'sd0);
    // Drain to empty
    send_command(OP_DELETE, $signed(32'h7FFF_FFFF));
    send_command(OP_DELETE, 32'sd0);
    send_command(OP_DELETE, -32'sd1);
    send_command(OP_DUMP, 32'sd0);
    send_command(OP_INSERT, $signed(32'h5555_AAAA));
    send_command(OP_SEARCH, $signed(32'h5555_AAAA));

    // Random part: fill to full, linger there a little, drain, repeat
    growing = 1'b1;
    for (int n = 0; n < RandomItems; n++) begin
      if (board.count == TableCap && $urandom_range(0, 3) == 0) growing = 1'b0;
      else if (board.count == 0) growing = 1'b1;
      if (n < RandomItems - QuietTail && (n / 40) % 3 != 2 && $urandom_range(0, 2) == 0)
        idle_gap($urandom_range(1, 6));
      random_command(growing);
    end
    start <= 1'b0;

    // Drain outstanding results, then let the block settle
    while (board.pending.size() != 0 || busy) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
